[rtl/cc20_pkg.sv]
package cc20_pkg;

  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 20;
  localparam int unsigned BLOCK_BYTES = 64;

  typedef logic [BLOCK_WORDS-1:0][31:0] word_arr_t;

  // "expand 32-byte k"
  localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

  // register indexes, byte address is 8 * index
  localparam logic [2:0] REG_KEY_0      = 3'd0;
  localparam logic [2:0] REG_KEY_1      = 3'd1;
  localparam logic [2:0] REG_KEY_2      = 3'd2;
  localparam logic [2:0] REG_KEY_3      = 3'd3;
  localparam logic [2:0] REG_NONCE_LOW  = 3'd4;
  localparam logic [2:0] REG_NONCE_HIGH = 3'd5;

  localparam logic [0:0] ACT_CRYPT   = 1'b0;
  localparam logic [0:0] ACT_RESTART = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_READ
  } ctl_state_e;

  typedef struct packed {
    logic       start;
    logic [3:0] sel;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
    return (v << n) | (v >> (6'd32 - {1'b0, n}));
  endfunction

endpackage

[rtl/cc20_core.sv]
module cc20_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cc20_pkg::core_ctrl_t ctrl_i,
  input  cc20_pkg::word_arr_t init_i,
  output cc20_pkg::core_stat_t stat_o,
  output logic [31:0]         ks_word_o
);
  import cc20_pkg::*;

  localparam logic [4:0] LAST_ROUND = 5'(ROUNDS - 1);

  word_arr_t  w_q, w_d;
  word_arr_t  init_q;
  logic       busy_q, busy_d;
  logic [4:0] rnd_q, rnd_d;
  logic [1:0] step_q, step_d;
  logic       last_step;

  assign last_step = (rnd_q == LAST_ROUND) && (step_q == 2'd3);

  // one line of the quarter round on all four lanes per cycle
  always_comb begin
    logic [3:0]  ia, ib, ic, id;
    logic [1:0]  qq;
    logic [31:0] t;
    logic        diag;
    ia     = '0;
    ib     = '0;
    ic     = '0;
    id     = '0;
    qq     = '0;
    t      = '0;
    w_d    = w_q;
    busy_d = busy_q;
    rnd_d  = rnd_q;
    step_d = step_q;
    diag   = rnd_q[0];
    if (ctrl_i.start) begin
      w_d    = init_i;
      busy_d = 1'b1;
      rnd_d  = '0;
      step_d = '0;
    end else if (busy_q) begin
      for (int q = 0; q < 4; q++) begin
        qq = 2'(q);
        ia = {2'b00, qq};
        ib = {2'b01, qq + {1'b0, diag}};
        ic = {2'b10, qq + {diag, 1'b0}};
        id = {2'b11, qq + {diag, diag}};
        case (step_q)
          2'd0: begin
            t      = w_q[ia] + w_q[ib];
            w_d[ia] = t;
            w_d[id] = rotl32(w_q[id] ^ t, 5'd16);
          end
          2'd1: begin
            t      = w_q[ic] + w_q[id];
            w_d[ic] = t;
            w_d[ib] = rotl32(w_q[ib] ^ t, 5'd12);
          end
          2'd2: begin
            t      = w_q[ia] + w_q[ib];
            w_d[ia] = t;
            w_d[id] = rotl32(w_q[id] ^ t, 5'd8);
          end
          default: begin
            t      = w_q[ic] + w_q[id];
            w_d[ic] = t;
            w_d[ib] = rotl32(w_q[ib] ^ t, 5'd7);
          end
        endcase
      end
      step_d = step_q + 2'd1;
      if (step_q == 2'd3) begin
        rnd_d = rnd_q + 5'd1;
      end
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= '0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      rnd_q  <= rnd_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    if (ctrl_i.start) begin
      init_q <= init_i;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && last_step;
  assign ks_word_o   = w_q[ctrl_i.sel] + init_q[ctrl_i.sel];

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> !busy_q)
    else $error("core started while busy");

  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done |=> !busy_q && rnd_q == 5'(ROUNDS) && step_q == 2'd0)
    else $error("core finished after wrong round count");

endmodule

[rtl/chacha20_stream_xor.sv]
// channel  dir  handshake                     payload
// in       in   in_valid_i / in_ready_o       action_i, data_in_i
// out      out  out_valid_o / out_ready_i     data_out_o
// cfg      in   psel, penable, pwrite, pready paddr, pwdata, prdata
//
// a crypt request with bytes left in the block reads its keystream word into a register,
// then xors the selected byte with the input byte into the output register
// a crypt request on a used-up block first runs the 20 rounds of the block function and
// writes the 16 words back into the keystream memory; a restart request answers next cycle
// the next request is taken only once the previous result has been taken
// reset: registers zero, block counter 1, position 64 so the first byte makes a block
module chacha20_stream_xor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  data_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  data_out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import cc20_pkg::*;

  ctl_state_e  state_q, state_d;
  logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce_lo_q;
  logic [31:0] nonce_hi_q;
  logic [6:0]  pos_q, pos_d;
  logic [31:0] cnt_q, cnt_d;
  logic [3:0]  widx_q, widx_d;
  logic [1:0]  bsel_q, bsel_d;
  logic [7:0]  din_q, din_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  data_out_q, data_out_d;

  logic        in_fire, cfg_we;
  logic [2:0]  reg_idx;
  word_arr_t   init_w;
  core_ctrl_t  core_ctrl;
  core_stat_t  core_stat;
  logic [31:0] ks_word;

  logic [31:0] ks_mem [BLOCK_WORDS];
  logic        mem_we, mem_re;
  logic [3:0]  mem_raddr;
  logic [31:0] mem_rdata_q;
  logic [7:0]  ks_byte;

  assign in_ready_o  = (state_q == ST_IDLE) && !out_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_out_q;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_KEY_0:      prdata = key0_q;
      REG_KEY_1:      prdata = key1_q;
      REG_KEY_2:      prdata = key2_q;
      REG_KEY_3:      prdata = key3_q;
      REG_NONCE_LOW:  prdata = nonce_lo_q;
      REG_NONCE_HIGH: prdata = {32'd0, nonce_hi_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q     <= '0;
      key1_q     <= '0;
      key2_q     <= '0;
      key3_q     <= '0;
      nonce_lo_q <= '0;
      nonce_hi_q <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_KEY_0:      key0_q     <= pwdata;
        REG_KEY_1:      key1_q     <= pwdata;
        REG_KEY_2:      key2_q     <= pwdata;
        REG_KEY_3:      key3_q     <= pwdata;
        REG_NONCE_LOW:  nonce_lo_q <= pwdata;
        REG_NONCE_HIGH: nonce_hi_q <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // block function input words
  always_comb begin
    init_w[0]  = SIGMA_0;
    init_w[1]  = SIGMA_1;
    init_w[2]  = SIGMA_2;
    init_w[3]  = SIGMA_3;
    init_w[4]  = key0_q[31:0];
    init_w[5]  = key0_q[63:32];
    init_w[6]  = key1_q[31:0];
    init_w[7]  = key1_q[63:32];
    init_w[8]  = key2_q[31:0];
    init_w[9]  = key2_q[63:32];
    init_w[10] = key3_q[31:0];
    init_w[11] = key3_q[63:32];
    init_w[12] = cnt_q;
    init_w[13] = nonce_lo_q[31:0];
    init_w[14] = nonce_lo_q[63:32];
    init_w[15] = nonce_hi_q;
  end

  cc20_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (core_ctrl),
    .init_i    (init_w),
    .stat_o    (core_stat),
    .ks_word_o (ks_word)
  );

  always_comb begin
    case (bsel_q)
      2'd0:    ks_byte = mem_rdata_q[7:0];
      2'd1:    ks_byte = mem_rdata_q[15:8];
      2'd2:    ks_byte = mem_rdata_q[23:16];
      default: ks_byte = mem_rdata_q[31:24];
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && action_i == ACT_CRYPT) begin
          state_d = pos_q[6] ? ST_ROUND : ST_READ;
        end
      end
      ST_ROUND: begin
        if (core_stat.done) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (widx_q == 4'(BLOCK_WORDS - 1)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and control outputs
  always_comb begin
    pos_d          = pos_q;
    cnt_d          = cnt_q;
    widx_d         = widx_q;
    bsel_d         = bsel_q;
    din_d          = din_q;
    out_valid_d    = out_valid_q;
    data_out_d     = data_out_q;
    core_ctrl.start = 1'b0;
    core_ctrl.sel   = widx_q;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_raddr      = pos_q[5:2];
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          din_d = data_in_i;
          if (action_i == ACT_RESTART) begin
            cnt_d       = 32'd1;
            pos_d       = 7'(BLOCK_BYTES);
            data_out_d  = '0;
            out_valid_d = 1'b1;
          end else if (pos_q[6]) begin
            core_ctrl.start = 1'b1;
            cnt_d           = cnt_q + 32'd1;
            widx_d          = '0;
          end else begin
            mem_re = 1'b1;
            bsel_d = pos_q[1:0];
            pos_d  = pos_q + 7'd1;
          end
        end
      end
      ST_ROUND: ;
      ST_FINAL: begin
        mem_we = 1'b1;
        widx_d = widx_q + 4'd1;
        if (widx_q == 4'(BLOCK_WORDS - 1)) begin
          // fresh block, first byte comes from word 0
          mem_re    = 1'b1;
          mem_raddr = '0;
          bsel_d    = '0;
          pos_d     = 7'd1;
        end
      end
      ST_READ: begin
        data_out_d  = din_q ^ ks_byte;
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= 7'(BLOCK_BYTES);
      cnt_q       <= 32'd1;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      widx_q      <= widx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bsel_q     <= bsel_d;
    din_q      <= din_d;
    data_out_q <= data_out_d;
  end

  // keystream memory, one word per entry
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ks_mem[widx_q] <= ks_word;
    end
    if (mem_re) begin
      mem_rdata_q <= ks_mem[mem_raddr];
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 7'(BLOCK_BYTES))
    else $error("keystream position out of range");

  a_refill_on_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && action_i == ACT_CRYPT && pos_q[6] |=> state_q == ST_ROUND && core_stat.busy)
    else $error("used-up block did not start a refill");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && action_i == ACT_RESTART |=>
      cnt_q == 32'd1 && pos_q == 7'(BLOCK_BYTES) && out_valid_q && data_out_q == 8'd0)
    else $error("restart request mishandled");

  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> out_valid_q && state_q == ST_IDLE)
    else $error("keystream read produced no result");

  a_done_in_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_stat.done |-> state_q == ST_ROUND)
    else $error("round unit finished outside refill");

endmodule
